FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/bpa_pkg.sv
// Types and constants of the buddy page allocator
`default_nettype none
package bpa_pkg;
    localparam int NUM_PAGES  = 4096;
    localparam int NUM_ORDERS = 11;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int CNT_W      = PAGE_W + 1;
    localparam int ORD_W      = 4;
    localparam int OP_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef struct packed {
        logic ok;
        logic [PAGE_W-1:0] page;
    } link_t;

    typedef struct packed {
        logic load;
        logic add_push;
        logic al_search;
        logic pop_rd;
        logic pop_wb;
        logic push_hi;
        logic push_lo;
        logic walk_start;
        logic walk_step;
        logic walk_adv;
        logic unlink_wb;
        logic fr_push;
        logic set_fail;
        logic out_load;
    } bpa_cmd_t;

    typedef struct packed {
        logic add_done;
        logic al_none;
        logic al_at_k;
        logic fr_bad;
        logic fr_top;
        logic walk_end;
        logic walk_hit;
    } bpa_stat_t;
endpackage
`default_nettype wire

FILE: hdl/bpa_ram.sv
// Generic RAM, one write port and one registered read port
`default_nettype none
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

FILE: hdl/bpa_ctrl.sv
// Sequencer of the buddy page allocator
`default_nettype none
module bpa_ctrl (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [bpa_pkg::OP_W-1:0]   s_operation,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    input  wire bpa_pkg::bpa_stat_t         stat,
    output bpa_pkg::bpa_cmd_t               cmd
);
    import bpa_pkg::*;

    typedef enum logic [12:0] {
        IDLE       = 13'b0000000000001,
        ADD_STEP   = 13'b0000000000010,
        AL_SEARCH  = 13'b0000000000100,
        AL_POP_RD  = 13'b0000000001000,
        AL_POP_WB  = 13'b0000000010000,
        AL_PUSH_HI = 13'b0000000100000,
        AL_PUSH_LO = 13'b0000001000000,
        FR_START   = 13'b0000010000000,
        FR_WALK    = 13'b0000100000000,
        FR_NEXT    = 13'b0001000000000,
        FR_UNLINK  = 13'b0010000000000,
        FR_PUSH    = 13'b0100000000000,
        FINISH     = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        case (state_reg)
            IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (s_operation)
                        OP_ADD:   state_next = ADD_STEP;
                        OP_ALLOC: state_next = AL_SEARCH;
                        OP_FREE:  state_next = FR_START;
                        default:  state_next = FINISH;
                    endcase
                end
            end
            ADD_STEP: begin
                if (stat.add_done) begin
                    state_next = FINISH;
                end else begin
                    cmd.add_push = 1'b1;
                end
            end
            AL_SEARCH: begin
                if (stat.al_none) begin
                    cmd.set_fail = 1'b1;
                    state_next   = FINISH;
                end else begin
                    cmd.al_search = 1'b1;
                    state_next    = AL_POP_RD;
                end
            end
            AL_POP_RD: begin
                cmd.pop_rd = 1'b1;
                state_next = AL_POP_WB;
            end
            AL_POP_WB: begin
                cmd.pop_wb = 1'b1;
                state_next = stat.al_at_k ? FINISH : AL_PUSH_HI;
            end
            AL_PUSH_HI: begin
                cmd.push_hi = 1'b1;
                state_next  = AL_PUSH_LO;
            end
            AL_PUSH_LO: begin
                cmd.push_lo = 1'b1;
                state_next  = AL_POP_RD;
            end
            FR_START: begin
                if (stat.fr_bad) begin
                    state_next = FINISH;
                end else if (stat.fr_top) begin
                    state_next = FR_PUSH;
                end else begin
                    cmd.walk_start = 1'b1;
                    state_next     = FR_WALK;
                end
            end
            FR_WALK: begin
                if (stat.walk_end) begin
                    state_next = FR_PUSH;
                end else if (stat.walk_hit) begin
                    state_next = FR_UNLINK;
                end else begin
                    cmd.walk_step = 1'b1;
                    state_next    = FR_NEXT;
                end
            end
            FR_NEXT: begin
                cmd.walk_adv = 1'b1;
                state_next   = FR_WALK;
            end
            FR_UNLINK: begin
                cmd.unlink_wb = 1'b1;
                state_next    = FR_START;
            end
            FR_PUSH: begin
                cmd.fr_push = 1'b1;
                state_next  = FINISH;
            end
            FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
endmodule
`default_nettype wire

FILE: hdl/bpa_dp.sv
// Datapath of the buddy page allocator: list heads, link memory, work registers
`default_nettype none
module bpa_dp (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [bpa_pkg::PAGE_W-1:0]  s_page,
    input  wire logic [bpa_pkg::ORD_W-1:0]   s_order,
    input  wire logic [bpa_pkg::CNT_W-1:0]   s_page_count,
    input  wire bpa_pkg::bpa_cmd_t           cmd,
    output bpa_pkg::bpa_stat_t               stat,
    output logic                             m_status,
    output logic [bpa_pkg::PAGE_W-1:0]       m_block_page
);
    import bpa_pkg::*;

    link_t              head_reg [NUM_ORDERS];
    logic [PAGE_W-1:0]  p_reg;
    logic [ORD_W-1:0]   k_reg;
    logic [ORD_W-1:0]   cur_reg;
    logic [CNT_W-1:0]   base_reg;
    logic [CNT_W-1:0]   size_reg;
    link_t              walk_reg;
    logic [PAGE_W-1:0]  prev_reg;
    logic               prev_head_reg;
    logic [CNT_W-1:0]   steps_reg;
    logic               fail_reg;
    logic [PAGE_W-1:0]  res_reg;
    logic               m_status_reg;
    logic [PAGE_W-1:0]  m_block_page_reg;

    logic [ORD_W-1:0]   add_k;
    logic [ORD_W-1:0]   found_k;
    logic               found_ok;
    logic [ORD_W-1:0]   hd_idx;
    link_t              hd_rd;
    logic [CNT_W-1:0]   room;
    logic [CNT_W-1:0]   add_blk;
    logic [PAGE_W-1:0]  half;
    logic               push_en;
    logic [PAGE_W-1:0]  push_page;
    logic               ram_we;
    logic [PAGE_W-1:0]  ram_waddr;
    link_t              ram_wdata;
    logic [PAGE_W-1:0]  ram_raddr;
    link_t              ram_rdata;

    // largest aligned block that fits in the remaining region
    always_comb begin
        add_k = '0;
        for (int i = 0; i < NUM_ORDERS; i++) begin
            if (((CNT_W'(1) << i) <= size_reg) &&
                ((base_reg & ((CNT_W'(1) << i) - CNT_W'(1))) == '0)) begin
                add_k = ORD_W'(i);
            end
        end
    end

    // smallest non-empty order at or above the request
    always_comb begin
        found_k  = '0;
        found_ok = 1'b0;
        for (int i = NUM_ORDERS - 1; i >= 0; i--) begin
            if ((ORD_W'(i) >= k_reg) && head_reg[i].ok) begin
                found_k  = ORD_W'(i);
                found_ok = 1'b1;
            end
        end
    end

    assign add_blk = CNT_W'(1) << add_k;
    assign half    = PAGE_W'(1) << (cur_reg - ORD_W'(1));
    assign room    = CNT_W'(NUM_PAGES) - {1'b0, s_page};

    always_comb begin
        hd_idx    = k_reg;
        push_en   = 1'b0;
        push_page = p_reg;
        if (cmd.add_push) begin
            hd_idx    = add_k;
            push_en   = 1'b1;
            push_page = base_reg[PAGE_W-1:0];
        end else if (cmd.pop_rd || cmd.pop_wb) begin
            hd_idx = cur_reg;
        end else if (cmd.push_hi) begin
            hd_idx    = cur_reg - ORD_W'(1);
            push_en   = 1'b1;
            push_page = p_reg + half;
        end else if (cmd.push_lo) begin
            hd_idx  = cur_reg - ORD_W'(1);
            push_en = 1'b1;
        end else if (cmd.fr_push) begin
            push_en = 1'b1;
        end
    end

    assign hd_rd = head_reg[hd_idx];

    always_comb begin
        ram_we    = push_en || (cmd.unlink_wb && !prev_head_reg);
        ram_waddr = push_en ? push_page : prev_reg;
        ram_wdata = push_en ? hd_rd : ram_rdata;
        ram_raddr = cmd.pop_rd ? hd_rd.page : walk_reg.page;
    end

    bpa_ram #(
        .WIDTH($bits(link_t)),
        .DEPTH(NUM_PAGES)
    ) u_links (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ORDERS; i++) begin
                head_reg[i] <= '0;
            end
        end else if (push_en) begin
            head_reg[hd_idx] <= '{ok: 1'b1, page: push_page};
        end else if (cmd.pop_wb || (cmd.unlink_wb && prev_head_reg)) begin
            head_reg[hd_idx] <= ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            p_reg    <= s_page & ~((PAGE_W'(1) << s_order) - PAGE_W'(1));
            k_reg    <= s_order;
            base_reg <= {1'b0, s_page};
            size_reg <= (s_page_count > room) ? room : s_page_count;
            fail_reg <= 1'b0;
            res_reg  <= '0;
        end
        if (cmd.add_push) begin
            base_reg <= base_reg + add_blk;
            size_reg <= size_reg - add_blk;
        end
        if (cmd.al_search) begin
            cur_reg <= found_k;
        end
        if (cmd.pop_rd) begin
            p_reg <= hd_rd.page;
        end
        if (cmd.pop_wb) begin
            res_reg <= p_reg;
        end
        if (cmd.push_lo) begin
            cur_reg <= cur_reg - ORD_W'(1);
        end
        if (cmd.set_fail) begin
            fail_reg <= 1'b1;
        end
        if (cmd.walk_start) begin
            walk_reg      <= hd_rd;
            prev_head_reg <= 1'b1;
            steps_reg     <= '0;
        end
        if (cmd.walk_step) begin
            prev_reg      <= walk_reg.page;
            prev_head_reg <= 1'b0;
            steps_reg     <= steps_reg + CNT_W'(1);
        end
        if (cmd.walk_adv) begin
            walk_reg <= ram_rdata;
        end
        if (cmd.unlink_wb) begin
            p_reg <= p_reg & ~(PAGE_W'(1) << k_reg);
            k_reg <= k_reg + ORD_W'(1);
        end
        if (cmd.out_load) begin
            m_status_reg     <= fail_reg;
            m_block_page_reg <= res_reg;
        end
    end

    always_comb begin
        stat.add_done = (size_reg == '0);
        stat.al_none  = !found_ok;
        stat.al_at_k  = (cur_reg == k_reg);
        stat.fr_bad   = (k_reg >= ORD_W'(NUM_ORDERS));
        stat.fr_top   = (k_reg == ORD_W'(NUM_ORDERS - 1));
        stat.walk_end = !walk_reg.ok || (steps_reg == CNT_W'(NUM_PAGES));
        stat.walk_hit = (walk_reg.page == (p_reg ^ (PAGE_W'(1) << k_reg)));
    end

    assign m_status     = m_status_reg;
    assign m_block_page = m_block_page_reg;
endmodule
`default_nettype wire

FILE: hdl/buddy_page_allocator.sv
// Top level of the buddy page allocator
// One request is taken at a time and answered by one transfer. Add region pushes
// one block per step, then answers; allocate finds the smallest non-empty order
// at or above the request, splits down to it (a pop read, a pop write-back and
// pushes of the high and low halves per split), pops the result and answers, or
// answers at once on failure; free, per order visited, starts a walk, steps
// through the free-list entries and unlinks the buddy if found, then pushes the
// merged block and answers. A new result waits while the previous one is stalled.
// The free-list walk dominates: every link comes from a 4096-entry link memory
// with a registered read. The link memory needs no clearing after reset.
`default_nettype none
module buddy_page_allocator (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [bpa_pkg::OP_W-1:0]    s_operation,
    input  wire logic [bpa_pkg::PAGE_W-1:0]  s_page,
    input  wire logic [bpa_pkg::ORD_W-1:0]   s_order,
    input  wire logic [bpa_pkg::CNT_W-1:0]   s_page_count,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_status,
    output logic [bpa_pkg::PAGE_W-1:0]       m_block_page
);
    import bpa_pkg::*;
`include "assert_macros.svh"

    bpa_cmd_t  cmd;
    bpa_stat_t stat;

    bpa_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_operation(s_operation),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    bpa_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_page      (s_page),
        .s_order     (s_order),
        .s_page_count(s_page_count),
        .cmd         (cmd),
        .stat        (stat),
        .m_status    (m_status),
        .m_block_page(m_block_page)
    );

    `ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `ASSERT_NOW(a_fail_no_page, aclk, aresetn, m_valid && m_status, m_block_page == '0)
    `ASSERT_NEXT(a_result_shown, aclk, aresetn, cmd.out_load, m_valid)
endmodule
`default_nettype wire

FILE: sim/buddy_page_allocator_tb.sv
// Testbench for the buddy page allocator: random and directed requests checked against a predictor
`timescale 1ns / 1ps
`default_nettype none

class alloc_scoreboard;
    typedef struct {
        logic                      status;
        logic [bpa_pkg::PAGE_W-1:0] page;
    } answer_t;

    int unsigned head_pg[bpa_pkg::NUM_ORDERS];
    bit          head_ok[bpa_pkg::NUM_ORDERS];
    int unsigned link_pg[bpa_pkg::NUM_PAGES];
    bit          link_ok[bpa_pkg::NUM_PAGES];
    answer_t     pending[$];
    answer_t     last;
    int          mismatches;

    function new();
        mismatches = 0;
        foreach (head_ok[i]) begin
            head_ok[i] = 0;
            head_pg[i] = 0;
        end
    endfunction

    function void push_blk(int unsigned k, int unsigned p);
        link_pg[p] = head_pg[k];
        link_ok[p] = head_ok[k];
        head_pg[k] = p;
        head_ok[k] = 1;
    endfunction

    function int unsigned pop_blk(int unsigned k);
        int unsigned p;
        p = head_pg[k];
        head_pg[k] = link_pg[p];
        head_ok[k] = link_ok[p];
        return p;
    endfunction

    function bit unlink_blk(int unsigned k, int unsigned target);
        bit          at_head;
        int unsigned prev;
        int unsigned cur;
        bit          ok;
        at_head = 1;
        prev = 0;
        ok = head_ok[k];
        cur = head_pg[k];
        for (int n = 0; ok && n < bpa_pkg::NUM_PAGES; n++) begin
            if (cur == target) begin
                if (at_head) begin
                    head_pg[k] = link_pg[cur];
                    head_ok[k] = link_ok[cur];
                end else begin
                    link_pg[prev] = link_pg[cur];
                    link_ok[prev] = link_ok[cur];
                end
                return 1;
            end
            at_head = 0;
            prev = cur;
            ok = link_ok[cur];
            cur = link_pg[cur];
        end
        return 0;
    endfunction

    function void note_request(bpa_pkg::op_t op, int unsigned page, int unsigned k,
                               int unsigned cnt);
        answer_t     a;
        int unsigned size;
        int unsigned kk;
        int unsigned cur;
        int unsigned p;
        int unsigned buddy;
        a.status = 0;
        a.page = 0;
        case (op)
            bpa_pkg::OP_ADD: begin
                size = (cnt > bpa_pkg::NUM_PAGES - page) ? bpa_pkg::NUM_PAGES - page : cnt;
                p = page;
                while (size > 0) begin
                    kk = bpa_pkg::NUM_ORDERS - 1;
                    while (kk > 0 && (1 << kk) > size) kk--;
                    while (kk > 0 && (p & ((1 << kk) - 1)) != 0) kk--;
                    push_blk(kk, p);
                    p += 1 << kk;
                    size -= 1 << kk;
                end
            end
            bpa_pkg::OP_ALLOC: begin
                cur = k;
                while (cur < bpa_pkg::NUM_ORDERS && !head_ok[cur]) cur++;
                if (cur >= bpa_pkg::NUM_ORDERS) begin
                    a.status = 1;
                end else begin
                    while (cur > k) begin
                        p = pop_blk(cur);
                        push_blk(cur - 1, p + (1 << (cur - 1)));
                        push_blk(cur - 1, p);
                        cur--;
                    end
                    a.page = bpa_pkg::PAGE_W'(pop_blk(k));
                end
            end
            bpa_pkg::OP_FREE: begin
                if (k < bpa_pkg::NUM_ORDERS) begin
                    kk = k;
                    p = page & ~((1 << kk) - 1);
                    if (p + (1 << kk) <= bpa_pkg::NUM_PAGES) begin
                        while (kk < bpa_pkg::NUM_ORDERS - 1) begin
                            buddy = p ^ (1 << kk);
                            if (!unlink_blk(kk, buddy)) break;
                            if (buddy < p) p = buddy;
                            kk++;
                        end
                        push_blk(kk, p);
                    end
                end
            end
            default: ;
        endcase
        last = a;
        pending.push_back(a);
    endfunction

    function void check_result(logic status, logic [bpa_pkg::PAGE_W-1:0] page);
        answer_t e;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected transfer: status %0d page %0d", status, page);
            return;
        end
        e = pending.pop_front();
        if (status !== e.status || page !== e.page) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected status %0d page %0d, got status %0d page %0d",
                         e.status, e.page, status, page);
        end
    endfunction
endclass

module buddy_page_allocator_tb;
    logic                         aclk;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [bpa_pkg::OP_W-1:0]     s_operation;
    logic [bpa_pkg::PAGE_W-1:0]   s_page;
    logic [bpa_pkg::ORD_W-1:0]    s_order;
    logic [bpa_pkg::CNT_W-1:0]    s_page_count;
    logic                         m_valid;
    logic                         m_ready;
    logic                         m_status;
    logic [bpa_pkg::PAGE_W-1:0]   m_block_page;

    alloc_scoreboard sb;
    int          send_idle_pct;
    int          recv_stall_pct;
    int unsigned owned_pg[$];
    int unsigned owned_ord[$];

    buddy_page_allocator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_page(s_page), .s_order(s_order), .s_page_count(s_page_count),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_block_page(m_block_page)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_block_page);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(bpa_pkg::op_t op, int unsigned page, int unsigned k,
                                int unsigned cnt);
        s_valid      <= 1;
        s_operation  <= op;
        s_page       <= bpa_pkg::PAGE_W'(page);
        s_order      <= bpa_pkg::ORD_W'(k);
        s_page_count <= bpa_pkg::CNT_W'(cnt);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(op, page & 32'hFFF, k & 32'hF, cnt & 32'h1FFF);
        if (op == bpa_pkg::OP_ALLOC && sb.last.status == 0) begin
            owned_pg.push_back(sb.last.page);
            owned_ord.push_back(k);
        end
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic free_owned();
        int          i;
        int unsigned p;
        int unsigned k;
        i = $urandom_range(owned_pg.size() - 1);
        p = owned_pg[i];
        k = owned_ord[i];
        owned_pg.delete(i);
        owned_ord.delete(i);
        if ($urandom_range(3) == 0)
            p = p | ($urandom & ((1 << k) - 1));
        send_request(bpa_pkg::OP_FREE, p, k, $urandom_range(8191));
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            send_request(bpa_pkg::OP_NONE, $urandom, $urandom, $urandom);
        else if (r < 12)
            send_request(bpa_pkg::OP_FREE, $urandom, $urandom_range(11, 15), $urandom);
        else if (r < 15)
            send_request(bpa_pkg::OP_ALLOC, $urandom, $urandom_range(11, 15), $urandom);
        else if (r < 55 && owned_pg.size() > 0)
            free_owned();
        else if (r < 90)
            send_request(bpa_pkg::OP_ALLOC, $urandom, $urandom_range(0, 4), $urandom);
        else
            send_request(bpa_pkg::OP_ALLOC, $urandom, $urandom_range(0, 10), $urandom);
    endtask

    initial begin
        int unsigned p;
        sb = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        aresetn      = 0;
        s_valid      = 0;
        s_operation  = bpa_pkg::OP_NONE;
        s_page       = 0;
        s_order      = 0;
        s_page_count = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_request(bpa_pkg::OP_ALLOC, 0, 0, 0);
        send_request(bpa_pkg::OP_ADD, 0, 0, 0);
        send_request(bpa_pkg::OP_ADD, 4095, 0, 4096);
        send_request(bpa_pkg::OP_ADD, 1, 0, 4094);
        send_request(bpa_pkg::OP_ADD, 0, 0, 1);
        send_request(bpa_pkg::OP_ALLOC, 0, 10, 0);
        send_request(bpa_pkg::OP_ALLOC, 0, 0, 0);
        send_request(bpa_pkg::OP_ALLOC, 0, 3, 0);
        send_request(bpa_pkg::OP_ALLOC, 4095, 15, 8191);
        send_request(bpa_pkg::OP_ALLOC, 0, 11, 0);
        send_request(bpa_pkg::OP_FREE, 4095, 15, 8191);
        send_request(bpa_pkg::OP_NONE, 4095, 15, 8191);
        while (owned_pg.size() > 0) free_owned();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 63 : (ph == 3) ? 36 : 0;
            recv_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 36 : 0;
            repeat (145) random_item();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        send_request(bpa_pkg::OP_ALLOC, 0, 0, 0);
        p = sb.last.page;
        send_request(bpa_pkg::OP_FREE, p, 0, 0);
        send_request(bpa_pkg::OP_FREE, p, 0, 0);
        send_request(bpa_pkg::OP_ADD, 0, 0, 8);
        send_request(bpa_pkg::OP_ALLOC, 0, 0, 0);
        s_valid <= 0;

        while (sb.pending.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

`default_nettype wire

FILE: buddy_page_allocator.f
+incdir+hdl
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/bpa_ctrl.sv
hdl/bpa_dp.sv
hdl/buddy_page_allocator.sv
sim/buddy_page_allocator_tb.sv
